>>> design/rotated_ellipse_arc_points_core_assert.svh
// assertion macros for the rotated ellipse arc point generator
// used by the top level only, needs no package
`ifndef ROTATED_ELLIPSE_ARC_POINTS_CORE_ASSERT_SVH
`define ROTATED_ELLIPSE_ARC_POINTS_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define REAP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define REAP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/reap_pkg.sv
// shared constants, types and tables of the arc point generator
// no dependencies; used by reap_div, reap_cordic and the top level
`default_nettype none
package reap_pkg;

    localparam int unsigned DVD_W   = 40;   // divider dividend and quotient width
    localparam int unsigned DSR_W   = 8;    // divider divisor width
    localparam int unsigned TRIG_W  = 17;   // q15 sine and cosine
    localparam int unsigned ATAN_W  = 32;

    // one turn in 2^-20 degree units
    localparam logic signed [32:0] FULL_TURN   = 33'sd377487360;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    // binary angle = (r*512 + 22) / 45, split as 512*(r/45) + (512*(r%45) + 22)/45
    localparam logic [5:0]         BIN_DIVISOR   = 6'd45;
    localparam logic [14:0]        BIN_ROUND     = 15'd22;
    // r/45 as a reciprocal product, exact for r below one turn
    localparam logic [29:0]        RECIP45       = 30'd763549742;
    localparam int unsigned        RECIP45_SH    = 35;
    // remainder term divided by 45, exact below 2^15
    localparam logic [15:0]        RECIP45_LO    = 16'd46604;
    localparam int unsigned        RECIP45_LO_SH = 21;

    typedef logic signed [TRIG_W-1:0] t_trig;

    // arctangent table, 2^32 per turn
    function automatic logic [ATAN_W-1:0] atan_val(input logic [4:0] idx);
        logic [ATAN_W-1:0] v;
        begin
            case (idx)
                5'd0:    v = 32'd536870912;
                5'd1:    v = 32'd316933406;
                5'd2:    v = 32'd167458907;
                5'd3:    v = 32'd85004756;
                5'd4:    v = 32'd42667331;
                5'd5:    v = 32'd21354465;
                5'd6:    v = 32'd10679838;
                5'd7:    v = 32'd5340245;
                5'd8:    v = 32'd2670163;
                5'd9:    v = 32'd1335087;
                5'd10:   v = 32'd667544;
                5'd11:   v = 32'd333772;
                5'd12:   v = 32'd166886;
                5'd13:   v = 32'd83443;
                5'd14:   v = 32'd41722;
                5'd15:   v = 32'd20861;
                5'd16:   v = 32'd10430;
                5'd17:   v = 32'd5215;
                5'd18:   v = 32'd2608;
                5'd19:   v = 32'd1304;
                5'd20:   v = 32'd652;
                5'd21:   v = 32'd326;
                5'd22:   v = 32'd163;
                5'd23:   v = 32'd81;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

    // step divisor: point count doubled until it reaches ten
    function automatic logic [DSR_W-1:0] step_divisor(input logic [6:0] n);
        logic [DSR_W-1:0] d;
        begin
            d = {1'b0, n};
            for (int k = 0; k < 4; k++) begin
                if (d < 8'd10) begin
                    d = d << 1;
                end
            end
            return d;
        end
    endfunction

endpackage
`default_nettype wire

>>> design/reap_div.sv
// restoring unsigned divider, one quotient bit per cycle
// depends on reap_pkg for widths
`default_nettype none
module reap_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [reap_pkg::DVD_W-1:0]  i_dividend,
    input  wire logic [reap_pkg::DSR_W-1:0]  i_divisor,
    output logic                             o_done,
    output logic [reap_pkg::DVD_W-1:0]       o_quotient
);
    localparam int unsigned CNT_W = $clog2(reap_pkg::DVD_W + 1);

    logic                          r_run;
    logic                          r_done;
    logic [CNT_W-1:0]              r_cnt;
    logic [reap_pkg::DSR_W:0]      r_rem;
    logic [reap_pkg::DVD_W-1:0]    r_quo;
    logic [reap_pkg::DSR_W-1:0]    r_dsr;
    logic [reap_pkg::DSR_W+1:0]    n_shift;
    logic [reap_pkg::DSR_W+1:0]    n_diff;

    // shift in the next dividend bit and trial subtract
    always_comb begin
        n_shift = {r_rem, r_quo[reap_pkg::DVD_W-1]};
        n_diff  = n_shift - {2'b00, r_dsr};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CNT_W'(reap_pkg::DVD_W);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_run) begin
            if (!n_diff[reap_pkg::DSR_W+1]) begin
                r_rem <= n_diff[reap_pkg::DSR_W:0];
                r_quo <= {r_quo[reap_pkg::DVD_W-2:0], 1'b1};
            end else begin
                r_rem <= n_shift[reap_pkg::DSR_W:0];
                r_quo <= {r_quo[reap_pkg::DVD_W-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule
`default_nettype wire

>>> design/reap_cordic.sv
// iterative rotation-mode cordic, one micro-rotation per cycle
// depends on reap_pkg for the arctangent table and gain
`default_nettype none
module reap_cordic #(
    parameter int unsigned STEPS = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [31:0]         i_angle,
    output logic                     o_done,
    output reap_pkg::t_trig          o_sin,
    output reap_pkg::t_trig          o_cos
);
    localparam int unsigned CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic                      r_run;
    logic                      r_done;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_neg;
    logic signed [33:0]        r_x;
    logic signed [33:0]        r_y;
    logic signed [32:0]        r_z;
    logic signed [32:0]        n_z0;
    logic                      n_neg;
    logic signed [33:0]        n_dx;
    logic signed [33:0]        n_dy;
    logic signed [32:0]        n_atan;
    logic signed [33:0]        n_fx;
    logic signed [33:0]        n_fy;
    logic signed [33:0]        n_rx;
    logic signed [33:0]        n_ry;

    // fold the binary angle into the right half plane
    always_comb begin
        n_z0  = 33'($signed(i_angle));
        n_neg = 1'b0;
        if (n_z0 > 33'sh040000000) begin
            n_z0  = n_z0 - 33'sh080000000;
            n_neg = 1'b1;
        end else if (n_z0 < -33'sh040000000) begin
            n_z0  = n_z0 + 33'sh080000000;
            n_neg = 1'b1;
        end
    end

    // one micro-rotation
    always_comb begin
        n_dx   = r_x >>> r_cnt;
        n_dy   = r_y >>> r_cnt;
        n_atan = $signed({1'b0, reap_pkg::atan_val(5'(r_cnt))});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= reap_pkg::CORDIC_GAIN;
            r_y   <= '0;
            r_z   <= n_z0;
            r_neg <= n_neg;
        end else if (r_run) begin
            if (r_z >= 0) begin
                r_x <= r_x - n_dy;
                r_y <= r_y + n_dx;
                r_z <= r_z - n_atan;
            end else begin
                r_x <= r_x + n_dy;
                r_y <= r_y - n_dx;
                r_z <= r_z + n_atan;
            end
        end
    end

    // undo the fold and round to q15
    always_comb begin
        n_fx = r_neg ? -r_x : r_x;
        n_fy = r_neg ? -r_y : r_y;
        n_rx = (n_fx + 34'sd16384) >>> 15;
        n_ry = (n_fy + 34'sd16384) >>> 15;
    end

    assign o_done = r_done;
    assign o_cos  = n_rx[reap_pkg::TRIG_W-1:0];
    assign o_sin  = n_ry[reap_pkg::TRIG_W-1:0];
endmodule
`default_nettype wire

>>> design/rotated_ellipse_arc_points_core.sv
// rotated ellipse arc point generator, top level with sequencer and shared multiplier
// depends on reap_pkg, reap_div, reap_cordic and the assertion macro header
//
// channel   | dir | fields (lowest bit first)
// s_axis    | in  | center_x 24, center_y 24, semi_axis_a 23, semi_axis_b 23,
//           |     | arc_start 16, arc_end 16, rotation 16
// m_axis    | out | tdata: point_x 24, point_y 24; tuser: is_first; tlast: is_last
// cfg       | in  | point_count 7
//
// per request, one run of the bit-serial step divider and one angle pass for the rotation
// an angle pass: reduction modulo one turn, conversion to the binary angle, then the cordic
// each point adds a pass through the shared multiplier, the pack step and the output register
// s_axis_tready is high only while idle; a point waiting for its transfer stalls the sequencer
// reset is synchronous, active low; point_count resets to 16
`default_nettype none
module rotated_ellipse_arc_points_core #(
    parameter int unsigned MAX_POINTS   = 64,
    parameter int unsigned CORDIC_STEPS = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [6:0]    i_cfg_wdata,    // point_count
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [143:0]  s_axis_tdata,   // center_x, center_y, semi_axis_a,
                                               // semi_axis_b, arc_start, arc_end, rotation
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [47:0]        m_axis_tdata,   // point_x, point_y
    output logic [0:0]         m_axis_tuser,   // is_first
    output logic               m_axis_tlast    // is_last
);
    typedef enum logic [3:0] {
        S_IDLE, S_SPAN, S_RED, S_BIN, S_BREM, S_BFRAC, S_COR, S_MUL, S_PACK, S_EMIT
    } t_state;

    t_state                         r_state;
    logic [6:0]                     r_point_count;
    logic signed [23:0]             r_cx, r_cy;
    logic [22:0]                    r_a, r_b;
    logic signed [15:0]             r_st, r_rot;
    logic [6:0]                     r_n, r_idx;
    logic                           r_span_neg;
    logic signed [31:0]             r_step, r_cur;
    logic signed [32:0]             r_ang;
    logic                           r_is_rot;
    reap_pkg::t_trig                r_rs, r_rc, r_sn, r_cs;
    logic signed [40:0]             r_ac, r_bs;
    logic signed [59:0]             r_prod, r_accx, r_accy;
    logic [2:0]                     r_mstep;
    logic                           r_div_start;
    logic [reap_pkg::DVD_W-1:0]     r_div_dvd;
    logic [reap_pkg::DSR_W-1:0]     r_div_dsr;
    logic [28:0]                    r_bin_r;
    logic [22:0]                    r_bin_q;
    logic [5:0]                     r_bin_m;
    logic                           r_cor_start;
    logic [31:0]                    r_cor_ang;
    logic                           r_ovalid, r_ofirst, r_olast;
    logic [23:0]                    r_ox, r_oy;

    logic                           div_done;
    logic [reap_pkg::DVD_W-1:0]     div_quo;
    logic                           cor_done;
    reap_pkg::t_trig                cor_sin, cor_cos;

    logic [6:0]                     n_n;
    logic signed [16:0]             n_span;
    logic [16:0]                    n_span_mag;
    logic signed [41:0]             n_mul_a;
    logic signed [17:0]             n_mul_b;
    logic signed [59:0]             n_tx, n_ty;
    logic signed [33:0]             n_sx, n_sy;
    logic signed [31:0]             n_step;
    logic [58:0]                    n_bin_prod;
    logic [28:0]                    n_bin_qm;
    logic [28:0]                    n_bin_rem;
    logic [14:0]                    n_bin_y;
    logic [30:0]                    n_bin_fprod;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= 7'd16;
        end else if (i_cfg_we) begin
            r_point_count <= i_cfg_wdata;
        end
    end

    // shared units
    reap_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_div_dvd),
        .i_divisor  (r_div_dsr),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    reap_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_cor_start),
        .i_angle (r_cor_ang),
        .o_done  (cor_done),
        .o_sin   (cor_sin),
        .o_cos   (cor_cos)
    );

    // clamped point count and span of the request
    always_comb begin
        n_n = (r_point_count == 7'd0) ? 7'd1 : r_point_count;
        if (int'(n_n) > int'(MAX_POINTS)) begin
            n_n = 7'(MAX_POINTS);
        end
        n_span     = 17'($signed(s_axis_tdata[125:110])) - 17'($signed(s_axis_tdata[109:94]));
        n_span_mag = n_span[16] ? 17'(-n_span) : 17'(n_span);
        n_step     = r_span_neg ? -$signed(div_quo[31:0]) : $signed(div_quo[31:0]);
    end

    // binary angle by reciprocal products: quotient, remainder, remainder term
    always_comb begin
        n_bin_prod  = {30'b0, r_bin_r} * {29'b0, reap_pkg::RECIP45};
        n_bin_qm    = {6'b0, r_bin_q} * {23'b0, reap_pkg::BIN_DIVISOR};
        n_bin_rem   = r_bin_r - n_bin_qm;
        n_bin_y     = {r_bin_m, 9'b0} + reap_pkg::BIN_ROUND;
        n_bin_fprod = {16'b0, n_bin_y} * {15'b0, reap_pkg::RECIP45_LO};
    end

    // shared multiplier operand selection
    always_comb begin
        case (r_mstep)
            3'd0: begin
                n_mul_a = 42'($signed({1'b0, r_a}));
                n_mul_b = 18'(r_cs);
            end
            3'd1: begin
                n_mul_a = 42'($signed({1'b0, r_b}));
                n_mul_b = 18'(r_sn);
            end
            3'd2: begin
                n_mul_a = 42'(r_ac);
                n_mul_b = 18'(r_rc);
            end
            3'd3: begin
                n_mul_a = 42'(r_bs);
                n_mul_b = 18'(r_rs);
            end
            3'd4: begin
                n_mul_a = 42'(r_ac);
                n_mul_b = 18'(r_rs);
            end
            3'd5: begin
                n_mul_a = 42'(r_bs);
                n_mul_b = 18'(r_rc);
            end
            default: begin
                n_mul_a = '0;
                n_mul_b = '0;
            end
        endcase
    end

    // rounding and center offset
    always_comb begin
        n_tx = (r_accx + 60'sd536870912) >>> 30;
        n_ty = (r_accy + 60'sd536870912) >>> 30;
        n_sx = 34'(r_cx) + n_tx[33:0];
        n_sy = 34'(r_cy) + n_ty[33:0];
    end

    function automatic logic [23:0] sat24(input logic signed [33:0] v);
        logic [23:0] r;
        begin
            if (v > 34'sd8388607) begin
                r = 24'h7FFFFF;
            end else if (v < -34'sd8388608) begin
                r = 24'h800000;
            end else begin
                r = v[23:0];
            end
            return r;
        end
    endfunction

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_start <= 1'b0;
            r_cor_start <= 1'b0;
            r_ovalid    <= 1'b0;
            r_idx       <= '0;
            r_n         <= 7'd1;
            r_mstep     <= '0;
        end else begin
            r_div_start <= 1'b0;
            r_cor_start <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_cx        <= s_axis_tdata[23:0];
                        r_cy        <= s_axis_tdata[47:24];
                        r_a         <= s_axis_tdata[70:48];
                        r_b         <= s_axis_tdata[93:71];
                        r_st        <= s_axis_tdata[109:94];
                        r_rot       <= s_axis_tdata[141:126];
                        r_n         <= n_n;
                        r_idx       <= '0;
                        r_span_neg  <= n_span[16];
                        r_div_dvd   <= {{(reap_pkg::DVD_W-31){1'b0}}, n_span_mag[16:0], 14'b0};
                        r_div_dsr   <= reap_pkg::step_divisor(n_n);
                        r_div_start <= 1'b1;
                        r_state     <= S_SPAN;
                    end
                end
                S_SPAN: begin
                    if (div_done) begin
                        r_step   <= n_step;
                        r_ang    <= {{3{r_rot[15]}}, r_rot, 14'b0};
                        r_is_rot <= 1'b1;
                        r_state  <= S_RED;
                    end
                end
                // reduce modulo one turn, then convert to a binary angle
                S_RED: begin
                    if (r_ang < 0) begin
                        r_ang <= r_ang + reap_pkg::FULL_TURN;
                    end else if (r_ang >= reap_pkg::FULL_TURN) begin
                        r_ang <= r_ang - reap_pkg::FULL_TURN;
                    end else begin
                        r_bin_r <= r_ang[28:0];
                        r_state <= S_BIN;
                    end
                end
                S_BIN: begin
                    r_bin_q <= n_bin_prod[reap_pkg::RECIP45_SH +: 23];
                    r_state <= S_BREM;
                end
                S_BREM: begin
                    r_bin_m <= n_bin_rem[5:0];
                    r_state <= S_BFRAC;
                end
                S_BFRAC: begin
                    r_cor_ang   <= {r_bin_q, n_bin_fprod[reap_pkg::RECIP45_LO_SH +: 9]};
                    r_cor_start <= 1'b1;
                    r_state     <= S_COR;
                end
                S_COR: begin
                    if (cor_done) begin
                        if (r_is_rot) begin
                            r_rs     <= cor_sin;
                            r_rc     <= cor_cos;
                            r_is_rot <= 1'b0;
                            r_cur    <= {{2{r_st[15]}}, r_st, 14'b0};
                            r_ang    <= {{3{r_st[15]}}, r_st, 14'b0};
                            r_state  <= S_RED;
                        end else begin
                            r_sn    <= cor_sin;
                            r_cs    <= cor_cos;
                            r_mstep <= '0;
                            r_state <= S_MUL;
                        end
                    end
                end
                // issue one product per cycle, fold in the previous one
                S_MUL: begin
                    r_prod  <= n_mul_a * n_mul_b;
                    r_mstep <= r_mstep + 1'b1;
                    case (r_mstep)
                        3'd1:    r_ac   <= r_prod[40:0];
                        3'd2:    r_bs   <= r_prod[40:0];
                        3'd3:    r_accx <= r_prod;
                        3'd4:    r_accx <= r_accx - r_prod;
                        3'd5:    r_accy <= r_prod;
                        3'd6: begin
                            r_accy  <= r_accy + r_prod;
                            r_state <= S_PACK;
                        end
                        default: ;
                    endcase
                end
                S_PACK: begin
                    r_ox     <= sat24(n_sx);
                    r_oy     <= sat24(n_sy);
                    r_ofirst <= (r_idx == 7'd0);
                    r_olast  <= (r_idx == r_n - 7'd1);
                    r_ovalid <= 1'b1;
                    r_state  <= S_EMIT;
                end
                S_EMIT: begin
                    if (m_axis_tready) begin
                        r_ovalid <= 1'b0;
                        if (r_olast) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + 7'd1;
                            r_cur   <= r_cur + r_step;
                            r_ang   <= 33'(r_cur + r_step);
                            r_state <= S_RED;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_oy, r_ox};
    assign m_axis_tuser  = r_ofirst;
    assign m_axis_tlast  = r_olast;

`include "rotated_ellipse_arc_points_core_assert.svh"

    // no request is taken while a point waits
    `REAP_ASSERT_NOW(a_no_overlap, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready, "input ready while a point waits")
    // point index stays below the count while busy
    `REAP_ASSERT_NOW(a_idx_range, i_clk, i_rst_n, !s_axis_tready, r_idx < r_n, "point index out of range")
    // the last point's transfer returns the block to idle
    `REAP_ASSERT_NEXT(a_last_idle, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready && m_axis_tlast, s_axis_tready, "not idle after last point")
    // first flag only on point zero
    `REAP_ASSERT_NOW(a_first_idx, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0], r_idx == 7'd0, "first flag on a later point")

endmodule
`default_nettype wire

>>> test/tb_rotated_ellipse_arc_points_core.sv
// self-checking testbench for the rotated ellipse arc point generator
// drives arc requests, predicts every point and compares each output transfer
// depends on rotated_ellipse_arc_points_core only
module tb_rotated_ellipse_arc_points_core;

    localparam int   MAX_PTS     = 64;
    localparam int   CORDIC_ITER = 16;
    localparam longint TURN_FINE = 64'sd377487360;
    localparam longint GAIN_Q30  = 64'sd652032874;
    localparam int   CYCLE_LIMIT = 4000000;
    localparam int   N_PHASES    = 15;

    typedef struct {
        logic signed [23:0] cx;
        logic signed [23:0] cy;
        logic [22:0]        a;
        logic [22:0]        b;
        logic signed [15:0] st;
        logic signed [15:0] en;
        logic signed [15:0] rot;
        bit                 fixed;  // expected points lie on the centre
    } arc_req_t;

    typedef struct {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic               first;
        logic               last;
    } arc_point_t;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_cfg_we = 1'b0;
    logic [6:0]    i_cfg_wdata = '0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [143:0]  s_axis_tdata = '0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [47:0]   m_axis_tdata;
    logic [0:0]    m_axis_tuser;
    logic          m_axis_tlast;

    arc_point_t pending_points[$];
    int         mismatches = 0;
    int         cycles = 0;
    bit         no_idle = 1'b0;
    logic [6:0] point_count_reg = 7'd16;

    longint atan_q32[16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
        21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861};

    rotated_ellipse_arc_points_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // cycle count and timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("rotated_ellipse_arc_points_core regression: fail");
            $finish;
        end
    end

    // q15 sine and cosine of a fine angle (2^-20 degree)
    task automatic fine_sincos(input longint ang, output longint sn, output longint cs);
        longint r, z, x, y, dx, dy;
        longint unsigned bin;
        bit neg;
        neg = 1'b0;
        r = ang % TURN_FINE;
        if (r < 0) r += TURN_FINE;
        bin = ((longint'(r) * 512 + 22) / 45) & 64'hFFFF_FFFF;
        z = (bin >= 64'h8000_0000) ? longint'(bin) - 64'sh1_0000_0000 : longint'(bin);
        if (z > 64'sh4000_0000) begin
            z -= 64'sh8000_0000;
            neg = 1'b1;
        end else if (z < -64'sh4000_0000) begin
            z += 64'sh8000_0000;
            neg = 1'b1;
        end
        x = GAIN_Q30;
        y = 0;
        for (int i = 0; i < CORDIC_ITER; i++) begin
            dx = x >>> i;
            dy = y >>> i;
            if (z >= 0) begin
                x -= dy; y += dx; z -= atan_q32[i];
            end else begin
                x += dy; y -= dx; z += atan_q32[i];
            end
        end
        if (neg) begin
            x = -x;
            y = -y;
        end
        sn = (y + 16384) >>> 15;
        cs = (x + 16384) >>> 15;
    endtask

    function automatic logic signed [23:0] clip24(input longint v);
        if (v > 8388607) return 24'sh7FFFFF;
        if (v < -8388608) return 24'sh800000;
        return v[23:0];
    endfunction

    // expected points of one accepted request
    task automatic arc_points_predict(input arc_req_t rq);
        longint n, div, st, en, stepv, ang, rs, rc, sn, cs, ac, bs, tx, ty;
        arc_point_t p;
        n = longint'(point_count_reg);
        if (n < 1) n = 1;
        if (n > MAX_PTS) n = MAX_PTS;
        div = n;
        while (div < 10) div *= 2;
        st = longint'(rq.st) * 16384;
        en = longint'(rq.en) * 16384;
        stepv = (en - st) / div;
        fine_sincos(longint'(rq.rot) * 16384, rs, rc);
        for (longint i = 0; i < n; i++) begin
            if (rq.fixed) begin
                p.x = rq.cx;
                p.y = rq.cy;
            end else begin
                ang = st + i * stepv;
                fine_sincos(ang, sn, cs);
                ac = longint'(rq.a) * cs;
                bs = longint'(rq.b) * sn;
                tx = (ac * rc - bs * rs + (64'sd1 <<< 29)) >>> 30;
                ty = (ac * rs + bs * rc + (64'sd1 <<< 29)) >>> 30;
                p.x = clip24(longint'(rq.cx) + tx);
                p.y = clip24(longint'(rq.cy) + ty);
            end
            p.first = (i == 0);
            p.last = (i == n - 1);
            pending_points.push_back(p);
        end
    endtask

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 6);
    endfunction

    // one request transfer on the slave side
    task automatic send_arc(input arc_req_t rq);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, rq.rot, rq.en, rq.st, rq.b, rq.a, rq.cy, rq.cx};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        arc_points_predict(rq);
    endtask

    function automatic arc_req_t random_arc();
        arc_req_t rq;
        int kind;
        kind = $urandom_range(0, 9);
        rq.fixed = 1'b0;
        rq.cx = 24'($urandom());
        rq.cy = 24'($urandom());
        rq.a = 23'($urandom());
        rq.b = 23'($urandom());
        // keep most ellipses moderate so saturation stays a minority
        if (kind < 6) begin
            rq.cx = $signed(rq.cx) >>> $urandom_range(0, 12);
            rq.cy = $signed(rq.cy) >>> $urandom_range(0, 12);
            rq.a = rq.a >> $urandom_range(0, 12);
            rq.b = rq.b >> $urandom_range(0, 12);
        end
        rq.st = 16'($urandom_range(0, 46080) - 23040);
        rq.en = (kind == 7) ? rq.st : 16'($urandom_range(0, 46080) - 23040);
        rq.rot = 16'($urandom_range(0, 46080) - 23040);
        if (kind == 8) begin
            rq.a = '0;
            rq.b = 23'($urandom());
        end
        return rq;
    endfunction

    // master side: per-transfer stalls and field checks
    initial begin
        int gap;
        arc_point_t want;
        logic signed [23:0] got_x, got_y;
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
            got_x = m_axis_tdata[23:0];
            got_y = m_axis_tdata[47:24];
            if (pending_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected point x=%0d y=%0d", got_x, got_y);
            end else begin
                want = pending_points.pop_front();
                if (got_x !== want.x || got_y !== want.y ||
                    m_axis_tuser[0] !== want.first || m_axis_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("point mismatch: exp x=%0d y=%0d f=%0b l=%0b got x=%0d y=%0d f=%0b l=%0b",
                            want.x, want.y, want.first, want.last,
                            got_x, got_y, m_axis_tuser[0], m_axis_tlast);
                end
            end
        end
    end

    // stimulus
    initial begin
        arc_req_t directed[12];
        logic [6:0] phase_count[N_PHASES] = '{7'd16, 7'd1, 7'd0, 7'd5, 7'd2, 7'd10, 7'd9,
            7'd64, 7'd127, 7'd3, 7'd7, 7'd4, 7'd12, 7'd6, 7'd8};
        int n_items;
        //              cx           cy           a          b          st      en      rot
        directed[0]  = '{24'sd0, 24'sd0, 23'd0, 23'd0, 16'sd0, 16'sd0, 16'sd0, 1'b1};
        directed[1]  = '{24'sh7FFFFF, 24'sh800000, 23'd0, 23'd0, 16'sd0, 16'sd23040,
                         16'sd0, 1'b1};
        directed[2]  = '{24'sh800000, 24'sh7FFFFF, 23'd0, 23'd0, -16'sd23040, 16'sd23040,
                         16'sd23040, 1'b1};
        directed[3]  = '{24'sd0, 24'sd0, 23'h7FFFFF, 23'h7FFFFF, 16'sd0, 16'sd23040,
                         16'sd0, 1'b0};
        // zero span with overflow towards the top and the bottom
        directed[4]  = '{24'sh7FFFFF, 24'sd0, 23'h7FFFFF, 23'd0, 16'sd0, 16'sd0,
                         16'sd0, 1'b0};
        directed[5]  = '{24'sh800000, 24'sd0, 23'h7FFFFF, 23'h7FFFFF, 16'sd11520,
                         16'sd11520, 16'sd0, 1'b0};
        // end before start
        directed[6]  = '{24'sd1000, -24'sd2000, 23'd256000, 23'd128000, 16'sd23040,
                         -16'sd23040, 16'sd5760, 1'b0};
        directed[7]  = '{24'sd0, 24'sd0, 23'd65536, 23'd32768, 16'sd0, 16'sd5760,
                         -16'sd23040, 1'b0};
        directed[8]  = '{-24'sd5000, 24'sd5000, 23'd256000, 23'd128000, -16'sd23040,
                         16'sd23040, 16'sd2880, 1'b0};
        // quadrant boundaries of the cordic folding
        directed[9]  = '{24'sd0, 24'sd0, 23'd100000, 23'd50000, 16'sd5760, 16'sd17280,
                         16'sd11520, 1'b0};
        directed[10] = '{24'sd0, 24'sd0, 23'd0, 23'h7FFFFF, -16'sd17280, -16'sd5760,
                         16'sd17280, 1'b0};
        directed[11] = '{24'sd12345, 24'sd0, 23'd1, 23'd1, 16'sd1, 16'sd2, -16'sd1, 1'b0};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph > 0) begin
                // block idle: results drained, sequencer settled
                while (pending_points.size() != 0) @(posedge i_clk);
                repeat (30) @(posedge i_clk);
                i_cfg_we <= 1'b1;
                i_cfg_wdata <= phase_count[ph];
                @(posedge i_clk);
                i_cfg_we <= 1'b0;
                point_count_reg = phase_count[ph];
            end
            no_idle = (ph % 4 == 3);
            if (ph == 0) begin
                foreach (directed[i]) send_arc(directed[i]);
            end
            n_items = (phase_count[ph] > 7'd32) ? 6 : 32;
            for (int i = 0; i < n_items; i++) send_arc(random_arc());
            s_axis_tvalid <= 1'b0;
        end

        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("rotated_ellipse_arc_points_core regression: pass");
        end else begin
            $display("rotated_ellipse_arc_points_core regression: fail");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+design
design/reap_pkg.sv
design/reap_div.sv
design/reap_cordic.sv
design/rotated_ellipse_arc_points_core.sv
test/tb_rotated_ellipse_arc_points_core.sv
